### hw/rtl/cubic_sample_interpolator_macros.svh
// ----------------------------------------------------------------------------
// Cubic sample interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_SAMPLE_INTERPOLATOR_MACROS_SVH
`define CUBIC_SAMPLE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define CSI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CSI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/csi_pkg.sv
// ----------------------------------------------------------------------------
// Cubic sample interpolator package
// Shared types, constants and the arithmetic step table.
// ----------------------------------------------------------------------------
`default_nettype none

package csi_pkg;

  localparam int unsigned STORE_FRAMES_DEF = 65536;
  localparam int unsigned CNT_W            = 17;
  localparam int unsigned MAC_STEPS        = 14;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_RAW    = 2'd1,
    OP_SMOOTH = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    MK_MUL,
    MK_SET,
    MK_ADD,
    MK_LDB,
    MK_LDC
  } mac_kind_e;

  typedef enum logic [2:0] {
    MS_X1,
    MS_BL,
    MS_BH,
    MS_CL,
    MS_CM,
    MS_CH
  } mac_sel_e;

  typedef struct packed {
    mac_kind_e kind;
    mac_sel_e  sel;
  } mac_uop_t;

  typedef struct packed {
    logic       cap_in;
    logic       wr_en;
    logic       mod_init;
    logic       mod_step;
    logic       addr_ld;
    logic       rd_en;
    logic       cap_smp;
    logic [1:0] k;
    logic       mac_en;
    mac_uop_t   uop;
    logic       out_ld;
    logic       raw;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       loop;
    logic       mod_last;
  } status_t;

  // Horner evaluation of the cubic, one micro-op per step.
  function automatic mac_uop_t mac_uop(input logic [3:0] step);
    mac_uop_t u;
    case (step)
      4'd0:    u = '{kind: MK_MUL, sel: MS_X1};
      4'd1:    u = '{kind: MK_SET, sel: MS_X1};
      4'd2:    u = '{kind: MK_LDB, sel: MS_X1};
      4'd3:    u = '{kind: MK_MUL, sel: MS_BL};
      4'd4:    u = '{kind: MK_SET, sel: MS_BL};
      4'd5:    u = '{kind: MK_MUL, sel: MS_BH};
      4'd6:    u = '{kind: MK_ADD, sel: MS_BH};
      4'd7:    u = '{kind: MK_LDC, sel: MS_BH};
      4'd8:    u = '{kind: MK_MUL, sel: MS_CL};
      4'd9:    u = '{kind: MK_SET, sel: MS_CL};
      4'd10:   u = '{kind: MK_MUL, sel: MS_CM};
      4'd11:   u = '{kind: MK_ADD, sel: MS_CM};
      4'd12:   u = '{kind: MK_MUL, sel: MS_CH};
      4'd13:   u = '{kind: MK_ADD, sel: MS_CH};
      default: u = '{kind: MK_MUL, sel: MS_X1};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/csi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module csi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/csi_datapath.sv
// ----------------------------------------------------------------------------
// Cubic sample interpolator datapath
// Item registers, address unit with serial modulo, frame stores and cubic MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module csi_datapath #(
  parameter int unsigned STORE_FRAMES = csi_pkg::STORE_FRAMES_DEF
) (
  input  wire logic               clk_i,
  input  wire csi_pkg::cmd_t      cmd_i,
  output csi_pkg::status_t        status_o,
  input  wire logic [1:0]         op_i,
  input  wire logic signed [31:0] whole_i,
  input  wire logic [15:0]        frac_i,
  input  wire logic signed [15:0] wl_i,
  input  wire logic signed [15:0] wr_i,
  input  wire logic [16:0]        frame_count_i,
  input  wire logic               source_stereo_i,
  input  wire logic               loop_enable_i,
  input  wire logic               output_stereo_i,
  output logic signed [15:0]      out_left_o,
  output logic signed [15:0]      out_right_o
);

  import csi_pkg::*;

  localparam int unsigned AW = (STORE_FRAMES > 1) ? $clog2(STORE_FRAMES) : 1;
  localparam int unsigned CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

  logic [1:0]         op_q;
  logic signed [31:0] whole_q;
  logic [15:0]        frac_q;
  logic signed [15:0] wl_q, wr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      op_q    <= op_i;
      whole_q <= whole_i;
      frac_q  <= frac_i;
      wl_q    <= wl_i;
      wr_q    <= wr_i;
    end
  end

  // Effective frame count.
  logic [CW-1:0]    fc_ext, sf_ext, eff;
  logic [CNT_W-1:0] n;

  always_comb begin
    fc_ext = CW'(frame_count_i);
    sf_ext = CW'(STORE_FRAMES);
    if (fc_ext == '0) begin
      eff = CW'(1);
    end else if (fc_ext > sf_ext) begin
      eff = sf_ext;
    end else begin
      eff = fc_ext;
    end
    n = eff[CNT_W-1:0];
  end

  // Serial modulo of the 64-bit sign-extended position, one bit a cycle.
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [5:0]       mcnt_q;
  logic             mbit;
  logic [CNT_W:0]   trial;

  always_comb begin
    mbit  = mcnt_q[5] ? whole_q[31] : whole_q[mcnt_q[4:0]];
    trial = {rem_q, mbit};
    if (trial >= {1'b0, n}) begin
      rem_d = CNT_W'(trial - {1'b0, n});
    end else begin
      rem_d = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_init) begin
      rem_q  <= '0;
      mcnt_q <= 6'd63;
    end else if (cmd_i.mod_step) begin
      rem_q  <= rem_d;
      mcnt_q <= mcnt_q - 6'd1;
    end
  end

  // Frame address for tap k.
  logic [CNT_W-1:0]   addr_q, addr_d;
  logic signed [33:0] pos;
  logic [CNT_W:0]     addr_inc;

  always_comb begin
    pos      = {{2{whole_q[31]}}, whole_q} + 34'(cmd_i.k);
    addr_inc = {1'b0, addr_q} + (CNT_W + 1)'(1);
    if (loop_enable_i) begin
      if (cmd_i.k == 2'd0) begin
        addr_d = rem_q;
      end else if (pos == '0) begin
        addr_d = '0;
      end else if (addr_inc == {1'b0, n}) begin
        addr_d = '0;
      end else begin
        addr_d = addr_inc[CNT_W-1:0];
      end
    end else begin
      if (pos[33]) begin
        addr_d = '0;
      end else if (pos >= 34'(n)) begin
        addr_d = n - CNT_W'(1);
      end else begin
        addr_d = pos[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_ld) begin
      addr_q <= addr_d;
    end
  end

  logic [AW+CNT_W-1:0] raddr_ext;
  logic [AW-1:0]       raddr;
  logic                wr_ok;
  logic [15:0]         rd_l, rd_r;

  assign raddr_ext = {AW'(0), addr_q};
  assign raddr     = raddr_ext[AW-1:0];
  assign wr_ok     = {1'b0, whole_q} < 33'(STORE_FRAMES);

  csi_ram #(.WIDTH(16), .DEPTH(STORE_FRAMES)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && wr_ok),
    .waddr_i (whole_q[AW-1:0]),
    .wdata_i (wl_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_l)
  );

  csi_ram #(.WIDTH(16), .DEPTH(STORE_FRAMES)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en && wr_ok),
    .waddr_i (whole_q[AW-1:0]),
    .wdata_i (wr_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rd_r)
  );

  // Channel handling on the fetched frame.
  logic signed [15:0] lv, rv, ch [2];
  logic signed [16:0] sum, avg;

  always_comb begin
    lv  = rd_l;
    rv  = source_stereo_i ? rd_r : rd_l;
    sum = 17'(lv) + 17'(rv);
    // round toward zero for negative odd sums
    avg = (sum + 17'(sum[16] & sum[0])) >>> 1;
    if (output_stereo_i) begin
      ch[0] = lv;
      ch[1] = rv;
    end else begin
      ch[0] = avg[15:0];
      ch[1] = avg[15:0];
    end
  end

  logic signed [15:0] s_q [2][4];
  logic signed [15:0] res [2];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic signed [19:0] x1, x2, x3;
    logic signed [24:0] chunk;
    logic signed [16:0] fs;
    logic signed [41:0] prod_q;
    logic [5:0]         sh, sh_q;
    logic signed [73:0] pext, acc_q, tot;
    logic signed [37:0] b_q;
    logic signed [55:0] c_q;
    logic signed [24:0] vfl, v;

    always_ff @(posedge clk_i) begin
      if (cmd_i.cap_smp) begin
        s_q[g][cmd_i.k] <= ch[g];
      end
    end

    always_comb begin
      x1 = 20'sd3 * (20'(s_q[g][1]) - 20'(s_q[g][2])) + 20'(s_q[g][3]) - 20'(s_q[g][0]);
      x2 = 20'sd2 * 20'(s_q[g][0]) - 20'sd5 * 20'(s_q[g][1])
         + 20'sd4 * 20'(s_q[g][2]) - 20'(s_q[g][3]);
      x3 = 20'(s_q[g][2]) - 20'(s_q[g][0]);
      fs = $signed({1'b0, frac_q});
      case (cmd_i.uop.sel)
        MS_X1:   begin chunk = 25'(x1);                        sh = 6'd0;  end
        MS_BL:   begin chunk = $signed({9'd0, b_q[15:0]});     sh = 6'd0;  end
        MS_BH:   begin chunk = 25'($signed(b_q[37:16]));       sh = 6'd16; end
        MS_CL:   begin chunk = $signed({9'd0, c_q[15:0]});     sh = 6'd0;  end
        MS_CM:   begin chunk = $signed({9'd0, c_q[31:16]});    sh = 6'd16; end
        MS_CH:   begin chunk = 25'($signed(c_q[55:32]));       sh = 6'd32; end
        default: begin chunk = '0;                             sh = 6'd0;  end
      endcase
      pext = 74'(prod_q) <<< sh_q;
      tot  = (74'(s_q[g][1]) <<< 49) + acc_q;
      vfl  = tot[73:49];
      // truncate toward zero
      v    = vfl + 25'(tot[73] && (tot[48:0] != '0));
      if (v > 25'sd32767) begin
        res[g] = 16'sh7fff;
      end else if (v < -25'sd32768) begin
        res[g] = -16'sd32768;
      end else begin
        res[g] = v[15:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.mac_en) begin
        case (cmd_i.uop.kind)
          MK_MUL: begin
            prod_q <= chunk * fs;
            sh_q   <= sh;
          end
          MK_SET: acc_q <= pext;
          MK_ADD: acc_q <= acc_q + pext;
          MK_LDB: b_q   <= (38'(x2) <<< 16) + acc_q[37:0];
          MK_LDC: c_q   <= (56'(x3) <<< 32) + acc_q[55:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_left_o  <= cmd_i.raw ? s_q[0][0] : res[0];
      out_right_o <= cmd_i.raw ? s_q[1][0] : res[1];
    end
  end

  assign status_o.op       = op_q;
  assign status_o.loop     = loop_enable_i;
  assign status_o.mod_last = (mcnt_q == 6'd0);

endmodule

`default_nettype wire

### hw/rtl/csi_ctrl.sv
// ----------------------------------------------------------------------------
// Cubic sample interpolator controller
// Sequences capture, store write, address modulo, tap fetches and the MAC.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_sample_interpolator_macros.svh"

module csi_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire csi_pkg::status_t status_i,
  output csi_pkg::cmd_t     cmd_o
);

  import csi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MOD,
    ST_ADDR,
    ST_READ,
    ST_CAPT,
    ST_MAC,
    ST_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] k_q, k_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.k     = k_q;
    cmd_o.uop   = mac_uop(step_q);
    cmd_o.raw   = (status_i.op == OP_RAW);
    case (state_q)
      ST_IDLE: begin
        cmd_o.cap_in = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        k_d = 2'd0;
        case (status_i.op)
          OP_WRITE: begin
            cmd_o.wr_en = 1'b1;
            state_d     = ST_IDLE;
          end
          OP_RAW, OP_SMOOTH: begin
            cmd_o.mod_init = status_i.loop;
            state_d        = status_i.loop ? ST_MOD : ST_ADDR;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (status_i.mod_last) begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd_o.addr_ld = 1'b1;
        state_d       = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CAPT;
      end
      ST_CAPT: begin
        cmd_o.cap_smp = 1'b1;
        if (status_i.op == OP_RAW) begin
          state_d = ST_FIN;
        end else if (k_q == 2'd3) begin
          step_d  = 4'd0;
          state_d = ST_MAC;
        end else begin
          k_d     = k_q + 2'd1;
          state_d = ST_ADDR;
        end
      end
      ST_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (step_q == 4'(MAC_STEPS - 1)) begin
          state_d = ST_FIN;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= 2'd0;
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  `CSI_ASSERT_IMP(a_wr_only_on_write, cmd_o.wr_en, status_i.op == OP_WRITE, "store write on read item")
  `CSI_ASSERT_IMP(a_no_overwrite, cmd_o.out_ld, !out_valid_q || out_ready_i, "pending result overwritten")
  `CSI_ASSERT_NXT(a_cap_after_read, cmd_o.rd_en, cmd_o.cap_smp, "tap capture not after read")
  `CSI_ASSERT_NXT(a_mod_then_addr, cmd_o.mod_step && status_i.mod_last, cmd_o.addr_ld, "modulo end lost")

endmodule

`default_nettype wire

### hw/rtl/cubic_sample_interpolator.sv
// ----------------------------------------------------------------------------
// Cubic sample interpolator
// Frame store with raw and Catmull-Rom cubic reads, APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request: tuser is the operation (write, raw read,
//   smooth read), tdata the position and the samples to write. A write stores
//   one frame and returns nothing; each read returns one frame on m_axis.
//   Registers (frame_count, source_stereo, loop_enable, output_stereo) sit on
//   the APB port at 0x0, 0x4, 0x8, 0xC; change them only while idle.
// Sequencing, one request at a time, each read ending in the result register:
//   a write captures the request and stores the frame. A raw read loads the
//   tap address, reads the store and captures the tap; a smooth read makes
//   four such fetches through the store's one read port and runs the 14-step
//   cubic MAC. In loop mode a bit-serial modulo of the position comes first.
// Reset clears the control state and the registers to frame_count 1, mono
// source, clamp mode, stereo output; the store holds garbage until written.
// A stalled receiver keeps the result in the output register; the next
// request is still accepted and runs up to its result, then waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_sample_interpolator #(
  parameter int unsigned STORE_FRAMES = csi_pkg::STORE_FRAMES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // position_whole[31:0], position_frac[47:32], write_left[63:48],
  // write_right[79:64]
  input  wire logic [79:0] s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_left[15:0], out_right[31:16]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import csi_pkg::*;

  localparam logic [1:0] REG_FRAME_COUNT   = 2'd0;
  localparam logic [1:0] REG_SOURCE_STEREO = 2'd1;
  localparam logic [1:0] REG_LOOP_ENABLE   = 2'd2;
  localparam logic [1:0] REG_OUTPUT_STEREO = 2'd3;

  logic [16:0] frame_count_q;
  logic        source_stereo_q, loop_enable_q, output_stereo_q;
  logic        reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q   <= 17'd1;
      source_stereo_q <= 1'b0;
      loop_enable_q   <= 1'b0;
      output_stereo_q <= 1'b1;
    end else if (reg_wr) begin
      case (paddr[3:2])
        REG_FRAME_COUNT:   frame_count_q   <= pwdata[16:0];
        REG_SOURCE_STEREO: source_stereo_q <= pwdata[0];
        REG_LOOP_ENABLE:   loop_enable_q   <= pwdata[0];
        REG_OUTPUT_STEREO: output_stereo_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_COUNT:   prdata = {15'd0, frame_count_q};
      REG_SOURCE_STEREO: prdata = {31'd0, source_stereo_q};
      REG_LOOP_ENABLE:   prdata = {31'd0, loop_enable_q};
      REG_OUTPUT_STEREO: prdata = {31'd0, output_stereo_q};
      default:           prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t status;

  csi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  csi_datapath #(.STORE_FRAMES(STORE_FRAMES)) u_datapath (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .op_i            (s_axis_tuser),
    .whole_i         (s_axis_tdata[31:0]),
    .frac_i          (s_axis_tdata[47:32]),
    .wl_i            (s_axis_tdata[63:48]),
    .wr_i            (s_axis_tdata[79:64]),
    .frame_count_i   (frame_count_q),
    .source_stereo_i (source_stereo_q),
    .loop_enable_i   (loop_enable_q),
    .output_stereo_i (output_stereo_q),
    .out_left_o      (m_axis_tdata[15:0]),
    .out_right_o     (m_axis_tdata[31:16])
  );

endmodule

`default_nettype wire

### tb/cubic_sample_interpolator_tb.sv
// ----------------------------------------------------------------------------
// Cubic sample interpolator testbench
// Drives write, raw read and smooth read requests over the stream port and
// programs the APB registers while idle. A local predictor keeps its own frame
// store and register copies and checks every read result against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module cubic_sample_interpolator_tb;
  import csi_pkg::*;

  localparam int unsigned NFRAMES = 65536;
  localparam logic [3:0] ADDR_FRAME_COUNT = 4'h0;
  localparam logic [3:0] ADDR_SRC_STEREO  = 4'h4;
  localparam logic [3:0] ADDR_LOOP        = 4'h8;
  localparam logic [3:0] ADDR_OUT_STEREO  = 4'hC;
  localparam logic [1:0] OP_NONE          = 2'd3;

  typedef struct packed {
    logic signed [15:0] right;
    logic signed [15:0] left;
  } frame_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // position_whole[31:0], position_frac[47:32], write_left[63:48],
  // write_right[79:64]
  logic [79:0] s_axis_tdata;
  // operation[1:0]
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // out_left[15:0], out_right[31:16]
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cubic_sample_interpolator u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // predictor state
  logic signed [15:0] left_mem [NFRAMES];
  logic signed [15:0] right_mem [NFRAMES];
  bit                 written [NFRAMES];
  logic [16:0]        frame_count_q;
  bit                 src_stereo_q, loop_q, out_stereo_q;
  frame_t             frame_q[$];

  int unsigned errors;
  int unsigned n_results;
  int unsigned n_smooth;
  int unsigned n_raw;
  int unsigned n_writes;
  bit          idle_en;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #60ms;
    $display("cubic_sample_interpolator test failed");
    $finish;
  end

  function automatic longint unsigned eff_frames();
    if (frame_count_q == 0) return 1;
    if (frame_count_q > NFRAMES) return NFRAMES;
    return frame_count_q;
  endfunction

  function automatic longint unsigned frame_index(longint pos);
    longint unsigned n;
    n = eff_frames();
    if (loop_q) return longint'(unsigned'(pos)) % n;
    if (pos < 0) return 0;
    if (longint'(pos) >= longint'(n)) return n - 1;
    return pos;
  endfunction

  function automatic void load_frame(longint pos, output int l, output int r);
    longint unsigned a;
    a = frame_index(pos);
    l = int'(left_mem[a]);
    r = src_stereo_q ? int'(right_mem[a]) : l;
    if (!out_stereo_q) begin
      l = (l + r) / 2;
      r = l;
    end
  endfunction

  // Catmull-Rom blend, exact value truncated toward zero, clamped to int16
  function automatic logic signed [15:0] catmull_rom(int s0, int s1, int s2, int s3,
                                                     logic [15:0] t);
    logic signed [95:0] c1, c2, c3, sum, q;
    logic signed [95:0] ft;
    logic signed [95:0] v;
    ft = {80'd0, t};
    c1 = 3 * (s1 - s2) + s3 - s0;
    c2 = 2 * s0 - 5 * s1 + 4 * s2 - s3;
    c3 = s2 - s0;
    sum = ((c3 <<< 32) + ((c2 <<< 16) + c1 * ft) * ft) * ft;
    // truncating division toward zero
    q = sum / (96'sd1 <<< 49);
    v = s1 + q;
    // the sum s1 + exact fraction truncates toward zero, not q alone
    if (sum > 0 && v < 0 && (sum % (96'sd1 <<< 49)) != 0) v = v + 1;
    if (sum < 0 && v > 0 && (sum % (96'sd1 <<< 49)) != 0) v = v - 1;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic void predict(logic [1:0] op, logic [31:0] whole, logic [15:0] t,
                                  logic [15:0] wl, logic [15:0] wr);
    int l[4], r[4];
    frame_t f;
    longint pos;
    pos = longint'(signed'(whole));
    case (op)
      OP_WRITE: begin
        if (whole < NFRAMES) begin
          left_mem[whole] = wl;
          right_mem[whole] = wr;
          written[whole] = 1'b1;
        end
      end
      OP_RAW: begin
        load_frame(pos, l[0], r[0]);
        f.left = 16'(l[0]);
        f.right = 16'(r[0]);
        frame_q.push_back(f);
      end
      OP_SMOOTH: begin
        for (int k = 0; k < 4; k++) load_frame(pos + k, l[k], r[k]);
        f.left = catmull_rom(l[0], l[1], l[2], l[3], t);
        f.right = catmull_rom(r[0], r[1], r[2], r[3], t);
        frame_q.push_back(f);
      end
      default: ;
    endcase
  endfunction

  task automatic idle_gap();
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_request(logic [1:0] op, logic [31:0] whole, logic [15:0] t,
                              logic [15:0] wl, logic [15:0] wr);
    idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {wr, wl, t, whole};
    do @(posedge clk_i); while (!s_axis_tready);
    predict(op, whole, t, wl, wr);
    case (op)
      OP_WRITE:  n_writes++;
      OP_RAW:    n_raw++;
      OP_SMOOTH: n_smooth++;
      default: ;
    endcase
  endtask

  // result checker with random backpressure
  initial begin
    frame_t want, got;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (frame_q.size() == 0) begin
          $error("result with no request pending: %h", m_axis_tdata);
          errors++;
        end else begin
          want = frame_q.pop_front();
          n_results++;
          if (got.left !== want.left) begin
            $error("out_left expected %0d got %0d", want.left, got.left);
            errors++;
          end
          if (got.right !== want.right) begin
            $error("out_right expected %0d got %0d", want.right, got.right);
            errors++;
          end
        end
      end
      if (idle_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk_i);
    // writes and ignored requests may still run behind the last result
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [3:0] addr, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr)
      ADDR_FRAME_COUNT: frame_count_q = value[16:0];
      ADDR_SRC_STEREO:  src_stereo_q = value[0];
      ADDR_LOOP:        loop_q = value[0];
      ADDR_OUT_STEREO:  out_stereo_q = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] frames, bit src_st, bit lp, bit out_st);
    drain();
    write_reg(ADDR_FRAME_COUNT, frames);
    write_reg(ADDR_SRC_STEREO, 32'(src_st));
    write_reg(ADDR_LOOP, 32'(lp));
    write_reg(ADDR_OUT_STEREO, 32'(out_st));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // fill frames [base, base + n) so every reachable read hits written data
  task automatic fill_store(int unsigned base, int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_request(OP_WRITE, base + i, 16'($urandom), rand_sample(), rand_sample());
  endtask

  // read positions reach in-range and far out-of-range values
  function automatic logic [31:0] rand_whole(int unsigned n);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000 | $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, n + 2) - 2;
    endcase
  endfunction

  task automatic test_directed();
    configure(8, 1, 0, 1);
    send_request(OP_WRITE, 0, 16'h0, 16'h7FFF, 16'h8000);
    send_request(OP_WRITE, 1, 16'h0, 16'h8000, 16'h7FFF);
    send_request(OP_WRITE, 2, 16'h0, 16'h7FFF, 16'h8000);
    send_request(OP_WRITE, 3, 16'h0, 16'h8000, 16'h7FFF);
    for (int i = 4; i < 8; i++) send_request(OP_WRITE, i, 16'hFFFF, 16'h1234, 16'hEDCB);
    // writes beyond the store are dropped
    send_request(OP_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(OP_WRITE, NFRAMES, 16'h0, 16'h0, 16'h0);
    send_request(OP_NONE, 32'h3, 16'hFFFF, 16'h1, 16'h1);
    send_request(OP_RAW, 32'h8000_0000, 16'h0, 16'h0, 16'h0);
    send_request(OP_RAW, 32'h7FFF_FFFF, 16'h0, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 0, 16'h0, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 0, 16'hFFFF, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 0, 16'h8000, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 32'hFFFF_FFFE, 16'h4000, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 6, 16'hC000, 16'h0, 16'h0);
    configure(8, 1, 1, 0);
    send_request(OP_SMOOTH, 32'h8000_0001, 16'h1357, 16'h0, 16'h0);
    send_request(OP_RAW, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 32'h7FFF_FFFE, 16'hFFFF, 16'h0, 16'h0);
  endtask

  // out-of-range frame counts behave as their nearest limit
  task automatic test_count_limits();
    configure(0, 0, 0, 1);
    send_request(OP_RAW, 5, 16'h0, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 32'hFFFF_FFFF, 16'hABCD, 16'h0, 16'h0);
    configure(0, 1, 1, 0);
    send_request(OP_SMOOTH, $urandom, 16'h5555, 16'h0, 16'h0);
    configure(32'h1FFFF, 0, 0, 1);
    fill_store(0, 32);
    fill_store(NFRAMES - 4, 4);
    send_request(OP_RAW, 32'h0001_0005, 16'h0, 16'h0, 16'h0);
    send_request(OP_SMOOTH, 32'h0000_FFFD, 16'hFFFF, 16'h0, 16'h0);
    configure(NFRAMES, 1, 1, 1);
    send_request(OP_SMOOTH, 32'hFFFF_FFFE, 16'h8001, 16'h0, 16'h0);
    send_request(OP_RAW, 32'h8000_0000, 16'h0, 16'h0, 16'h0);
  endtask

  task automatic test_random(int unsigned n_req, bit with_idle);
    int unsigned n;
    logic [1:0] op;
    idle_en = with_idle;
    for (int unsigned i = 0; i < n_req; i++) begin
      if (i % 60 == 0) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(4, 24);
        configure(n, 1'($urandom), 1'($urandom), 1'($urandom));
      end
      if (i == n_req / 2) drain();
      n = 32'(eff_frames());
      case ($urandom_range(0, 9))
        0, 1: op = OP_WRITE;
        2:    op = ($urandom_range(0, 1) == 0) ? OP_NONE : OP_WRITE;
        3, 4: op = OP_RAW;
        default: op = OP_SMOOTH;
      endcase
      send_request(op, (op == OP_WRITE) ? $urandom_range(0, n - 1) : rand_whole(n),
                   16'($urandom), rand_sample(), rand_sample());
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    frame_count_q = 1;
    src_stereo_q = 1'b0;
    loop_q = 1'b0;
    out_stereo_q = 1'b1;
    idle_en = 1'b1;
    errors = 0;
    n_results = 0;
    n_smooth = 0;
    n_raw = 0;
    n_writes = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_count_limits();
    // the low frames are all written, so random frame counts stay safe
    test_random(300, 1'b1);
    test_random(90, 1'b0);
    drain();

    $display("covered %0d writes, %0d raw reads, %0d smooth reads, %0d results checked",
             n_writes, n_raw, n_smooth, n_results);
    $display("frame counts from 0 to past the store, clamp and loop, mono and stereo");
    if (errors == 0) begin
      $display("cubic_sample_interpolator test passed");
    end else begin
      $display("cubic_sample_interpolator test failed");
    end
    $finish;
  end

endmodule
